// ----- hw/rtl/vca_pkg.sv -----
`default_nettype none

package vca_pkg;

	localparam int DEF_NUM_CHANNELS  = 8;
	localparam int DEF_SOUND_ID_BITS = 8;

	localparam int HANDLE_W = 32;
	localparam int CLASS_W  = 2;
	localparam int KEY_W    = CLASS_W + HANDLE_W;

	localparam logic [2:0] ACT_PLAY     = 3'd0;
	localparam logic [2:0] ACT_STOP     = 3'd1;
	localparam logic [2:0] ACT_PAUSE    = 3'd2;
	localparam logic [2:0] ACT_RESUME   = 3'd3;
	localparam logic [2:0] ACT_QUERY    = 3'd4;
	localparam logic [2:0] ACT_STOP_ALL = 3'd5;
	localparam logic [2:0] ACT_UPDATE   = 3'd6;

	localparam logic [2:0] CMD_NONE     = 3'd0;
	localparam logic [2:0] CMD_START    = 3'd1;
	localparam logic [2:0] CMD_HALT     = 3'd2;
	localparam logic [2:0] CMD_PAUSE    = 3'd3;
	localparam logic [2:0] CMD_RESUME   = 3'd4;
	localparam logic [2:0] CMD_HALT_ALL = 3'd5;

	localparam logic [1:0] SND_STOPPED = 2'd0;
	localparam logic [1:0] SND_PLAYING = 2'd1;
	localparam logic [1:0] SND_PAUSED  = 2'd2;

	localparam logic [0:0] ST_DONE      = 1'b0;
	localparam logic [0:0] ST_NOT_FOUND = 1'b1;

	// Steal priority: lower class wins before the handle is compared.
	localparam logic [CLASS_W-1:0] CLS_SAME    = 2'd0;
	localparam logic [CLASS_W-1:0] CLS_ONESHOT = 2'd1;
	localparam logic [CLASS_W-1:0] CLS_ANY     = 2'd2;
	localparam logic [CLASS_W-1:0] CLS_NONE    = 2'd0;

	typedef struct packed {
		logic clear;
		logic en;
		logic find;
	} scan_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/vca_chan_mem.sv -----
`default_nettype none

module vca_chan_mem #(
	parameter int NUM_CHANNELS  = vca_pkg::DEF_NUM_CHANNELS,
	parameter int SOUND_ID_BITS = vca_pkg::DEF_SOUND_ID_BITS,
	localparam int CH_BITS = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [CH_BITS-1:0]            waddr,
	input  wire logic [vca_pkg::HANDLE_W-1:0]  wr_handle,
	input  wire logic [SOUND_ID_BITS-1:0]      wr_sound,
	input  wire logic                          wr_loop,
	input  wire logic                          re,
	input  wire logic [CH_BITS-1:0]            raddr,
	output logic      [vca_pkg::HANDLE_W-1:0]  rd_handle,
	output logic      [SOUND_ID_BITS-1:0]      rd_sound,
	output logic                               rd_loop
);

	logic [vca_pkg::HANDLE_W-1:0] handle_mem [NUM_CHANNELS];
	logic [SOUND_ID_BITS-1:0]     sound_mem  [NUM_CHANNELS];
	logic                         loop_mem   [NUM_CHANNELS];

	always_ff @(posedge clk) begin
		if (we) begin
			handle_mem[waddr] <= wr_handle;
			sound_mem[waddr]  <= wr_sound;
			loop_mem[waddr]   <= wr_loop;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_handle <= handle_mem[raddr];
			rd_sound  <= sound_mem[raddr];
			rd_loop   <= loop_mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/vca_scan.sv -----
`default_nettype none

module vca_scan #(
	parameter int NUM_CHANNELS = vca_pkg::DEF_NUM_CHANNELS,
	localparam int CH_BITS = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire vca_pkg::scan_ctl_t          ctl,
	input  wire logic [vca_pkg::KEY_W-1:0]   key,
	input  wire logic [vca_pkg::KEY_W-1:0]   target,
	input  wire logic [CH_BITS-1:0]          chan,
	output logic                             found,
	output logic      [CH_BITS-1:0]          best_chan
);

	logic [vca_pkg::KEY_W-1:0] best_key_q;
	logic [vca_pkg::KEY_W-1:0] operand;
	logic                      key_lt;
	logic                      key_eq;
	logic                      take;

	// One comparator serves both the handle lookup and the oldest-voice search.
	assign operand = ctl.find ? target : best_key_q;
	assign key_lt  = key < operand;
	assign key_eq  = key == operand;
	assign take    = ctl.en && (ctl.find ? (!found && key_eq) : (!found || key_lt));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found <= 1'b0;
		end else if (ctl.clear) begin
			found <= 1'b0;
		end else if (take) begin
			found <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_key_q <= key;
			best_chan  <= chan;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/voice_channel_allocator.sv -----
`default_nettype none

// Channel   Signals                                               Handshake
// request   action sound_id looping handle playing_mask           start, taken when !busy
// result    status sound_state channel new_handle mixer_cmd       done, one-cycle beat
//           loop_forever stolen freed_mask
//
// Play with a free channel, stop-all, update and unused actions go from start straight to
// the apply state, which registers done. Stop, pause, resume, query and a play that must
// steal a voice first pass through the scan, which reads one channel entry per cycle
// through the single read port of the channel memory and one shared comparator.
// A new beat may start in the cycle that done is high. Reset clears all channels and
// the handle counter at once. The receiver cannot stall the result beat.

module voice_channel_allocator #(
	parameter int NUM_CHANNELS  = vca_pkg::DEF_NUM_CHANNELS,
	parameter int SOUND_ID_BITS = vca_pkg::DEF_SOUND_ID_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  action,
	input  wire logic [7:0]  sound_id,
	input  wire logic        looping,
	input  wire logic [31:0] handle,
	input  wire logic [7:0]  playing_mask,
	output logic             done,
	output logic             status,
	output logic      [1:0]  sound_state,
	output logic      [2:0]  channel,
	output logic      [31:0] new_handle,
	output logic      [2:0]  mixer_cmd,
	output logic             loop_forever,
	output logic             stolen,
	output logic      [7:0]  freed_mask
);

	localparam int CH_BITS = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int UPD_N   = (NUM_CHANNELS < 8) ? NUM_CHANNELS : 8;
	localparam logic [CH_BITS-1:0] LAST_CH = CH_BITS'(NUM_CHANNELS - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_APPLY
	} state_t;

	state_t                          state_q;
	logic [2:0]                      action_q;
	logic [SOUND_ID_BITS-1:0]        snd_q;
	logic                            loop_q;
	logic [vca_pkg::HANDLE_W-1:0]    h_q;
	logic [7:0]                      pmask_q;
	logic                            free_hit_q;
	logic [CH_BITS-1:0]              free_idx_q;
	logic                            issue_q;
	logic [CH_BITS-1:0]              rd_idx_q;
	logic                            rd_v_s1;
	logic [CH_BITS-1:0]              rd_chan_s1;
	logic [NUM_CHANNELS-1:0]         valid_q;
	logic [NUM_CHANNELS-1:0]         paused_q;
	logic [vca_pkg::HANDLE_W-1:0]    last_handle_q;

	logic [15:0]                     sid_ext;
	logic [SOUND_ID_BITS-1:0]        snd_in;
	logic                            free_hit;
	logic [CH_BITS-1:0]              free_idx;

	logic [vca_pkg::HANDLE_W-1:0]    rd_handle;
	logic [SOUND_ID_BITS-1:0]        rd_sound;
	logic                            rd_loop;
	logic [vca_pkg::CLASS_W-1:0]     cls;
	logic [vca_pkg::KEY_W-1:0]       scan_key;
	logic [vca_pkg::KEY_W-1:0]       scan_target;
	vca_pkg::scan_ctl_t              scan_ctl;
	logic                            scan_found;
	logic [CH_BITS-1:0]              scan_chan;

	logic [CH_BITS-1:0]              k;
	logic [NUM_CHANNELS-1:0]         valid_nx;
	logic [NUM_CHANNELS-1:0]         paused_nx;
	logic [vca_pkg::HANDLE_W-1:0]    lh_nx;
	logic                            wr_en;
	logic                            res_status;
	logic [1:0]                      res_state;
	logic [CH_BITS-1:0]              res_chan;
	logic [vca_pkg::HANDLE_W-1:0]    res_nh;
	logic [2:0]                      res_cmd;
	logic                            res_lf;
	logic                            res_stolen;
	logic [7:0]                      res_freed;

	assign busy    = state_q != S_IDLE;
	assign sid_ext = {8'h00, sound_id};
	assign snd_in  = sid_ext[SOUND_ID_BITS-1:0];

	always_comb begin
		free_hit = 1'b0;
		free_idx = '0;
		for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_hit = 1'b1;
				free_idx = CH_BITS'(i);
			end
		end
	end

	vca_chan_mem #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.SOUND_ID_BITS(SOUND_ID_BITS)
	) u_mem (
		.clk      (clk),
		.we       (wr_en && (state_q == S_APPLY)),
		.waddr    (k),
		.wr_handle(lh_nx),
		.wr_sound (snd_q),
		.wr_loop  (loop_q),
		.re       (issue_q),
		.raddr    (rd_idx_q),
		.rd_handle(rd_handle),
		.rd_sound (rd_sound),
		.rd_loop  (rd_loop)
	);

	always_comb begin
		if (rd_sound == snd_q) begin
			cls = vca_pkg::CLS_SAME;
		end else if (!rd_loop) begin
			cls = vca_pkg::CLS_ONESHOT;
		end else begin
			cls = vca_pkg::CLS_ANY;
		end
	end

	assign scan_ctl.clear = (state_q == S_IDLE) && start;
	assign scan_ctl.en    = (state_q == S_SCAN) && rd_v_s1 && valid_q[rd_chan_s1];
	assign scan_ctl.find  = action_q != vca_pkg::ACT_PLAY;
	assign scan_key       = scan_ctl.find ? {vca_pkg::CLS_NONE, rd_handle} : {cls, rd_handle};
	assign scan_target    = {vca_pkg::CLS_NONE, h_q};

	vca_scan #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (scan_ctl),
		.key      (scan_key),
		.target   (scan_target),
		.chan     (rd_chan_s1),
		.found    (scan_found),
		.best_chan(scan_chan)
	);

	always_comb begin
		valid_nx   = valid_q;
		paused_nx  = paused_q;
		lh_nx      = last_handle_q;
		wr_en      = 1'b0;
		res_status = vca_pkg::ST_DONE;
		res_state  = vca_pkg::SND_STOPPED;
		res_chan   = '0;
		res_nh     = '0;
		res_cmd    = vca_pkg::CMD_NONE;
		res_lf     = 1'b0;
		res_stolen = 1'b0;
		res_freed  = '0;
		if (action_q == vca_pkg::ACT_PLAY) begin
			k = free_hit_q ? free_idx_q : (scan_found ? scan_chan : '0);
		end else begin
			k = scan_chan;
		end
		case (action_q)
			vca_pkg::ACT_PLAY: begin
				lh_nx        = last_handle_q + 32'd1;
				wr_en        = 1'b1;
				valid_nx[k]  = 1'b1;
				paused_nx[k] = 1'b0;
				res_chan     = k;
				res_nh       = lh_nx;
				res_cmd      = vca_pkg::CMD_START;
				res_lf       = loop_q;
				res_stolen   = !free_hit_q;
			end
			vca_pkg::ACT_STOP: begin
				if (!scan_found) begin
					res_status = vca_pkg::ST_NOT_FOUND;
				end else begin
					valid_nx[k]  = 1'b0;
					paused_nx[k] = 1'b0;
					res_cmd      = vca_pkg::CMD_HALT;
					res_chan     = k;
				end
			end
			vca_pkg::ACT_PAUSE: begin
				if (!scan_found) begin
					res_status = vca_pkg::ST_NOT_FOUND;
				end else if (!paused_q[k]) begin
					paused_nx[k] = 1'b1;
					res_cmd      = vca_pkg::CMD_PAUSE;
					res_chan     = k;
				end
			end
			vca_pkg::ACT_RESUME: begin
				if (!scan_found) begin
					res_status = vca_pkg::ST_NOT_FOUND;
				end else if (paused_q[k]) begin
					paused_nx[k] = 1'b0;
					res_cmd      = vca_pkg::CMD_RESUME;
					res_chan     = k;
				end
			end
			vca_pkg::ACT_QUERY: begin
				if (!scan_found) begin
					res_status = vca_pkg::ST_NOT_FOUND;
				end else begin
					res_state = paused_q[k] ? vca_pkg::SND_PAUSED : vca_pkg::SND_PLAYING;
				end
			end
			vca_pkg::ACT_STOP_ALL: begin
				valid_nx  = '0;
				paused_nx = '0;
				res_cmd   = vca_pkg::CMD_HALT_ALL;
			end
			vca_pkg::ACT_UPDATE: begin
				for (int i = 0; i < UPD_N; i++) begin
					if (valid_q[i] && !pmask_q[i]) begin
						valid_nx[i]  = 1'b0;
						paused_nx[i] = 1'b0;
						res_freed[i] = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			done          <= 1'b0;
			issue_q       <= 1'b0;
			rd_v_s1       <= 1'b0;
			valid_q       <= '0;
			paused_q      <= '0;
			last_handle_q <= '0;
			status        <= 1'b0;
			sound_state   <= '0;
			channel       <= '0;
			new_handle    <= '0;
			mixer_cmd     <= vca_pkg::CMD_NONE;
			loop_forever  <= 1'b0;
			stolen        <= 1'b0;
			freed_mask    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					done <= 1'b0;
					if (start) begin
						action_q   <= action;
						snd_q      <= snd_in;
						loop_q     <= looping;
						h_q        <= handle;
						pmask_q    <= playing_mask;
						free_hit_q <= free_hit;
						free_idx_q <= free_idx;
						rd_idx_q   <= '0;
						if (action == vca_pkg::ACT_PLAY && free_hit) begin
							state_q <= S_APPLY;
						end else if (action == vca_pkg::ACT_PLAY || action == vca_pkg::ACT_STOP ||
								action == vca_pkg::ACT_PAUSE || action == vca_pkg::ACT_RESUME ||
								action == vca_pkg::ACT_QUERY) begin
							state_q <= S_SCAN;
							issue_q <= 1'b1;
						end else begin
							state_q <= S_APPLY;
						end
					end
				end
				S_SCAN: begin
					rd_v_s1    <= issue_q;
					rd_chan_s1 <= rd_idx_q;
					if (issue_q) begin
						if (rd_idx_q == LAST_CH) begin
							issue_q <= 1'b0;
						end else begin
							rd_idx_q <= rd_idx_q + CH_BITS'(1);
						end
					end
					if (rd_v_s1 && rd_chan_s1 == LAST_CH) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					rd_v_s1       <= 1'b0;
					valid_q       <= valid_nx;
					paused_q      <= paused_nx;
					last_handle_q <= lh_nx;
					status        <= res_status;
					sound_state   <= res_state;
					channel       <= 3'(res_chan);
					new_handle    <= res_nh;
					mixer_cmd     <= res_cmd;
					loop_forever  <= res_lf;
					stolen        <= res_stolen;
					freed_mask    <= res_freed;
					done          <= 1'b1;
					state_q       <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/vca_checker.sv -----
`default_nettype none

module vca_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic        status,
	input wire logic [1:0]  sound_state,
	input wire logic [31:0] new_handle,
	input wire logic [2:0]  mixer_cmd,
	input wire logic        loop_forever,
	input wire logic        stolen
);

	// An accepted beat always makes the block busy.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	// A result appears only right after the block was working on a request.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) && !busy)
		else $error("result beat without a preceding busy cycle");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beat lasted more than one cycle");

	a_start_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && mixer_cmd != vca_pkg::CMD_START |->
			new_handle == 32'd0 && !loop_forever && !stolen)
		else $error("play fields set on a result that is not a start");

	a_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		done && status |-> mixer_cmd == vca_pkg::CMD_NONE &&
			sound_state == vca_pkg::SND_STOPPED)
		else $error("handle miss produced a mixer command or a state");

endmodule

bind voice_channel_allocator vca_checker u_vca_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.sound_state (sound_state),
	.new_handle  (new_handle),
	.mixer_cmd   (mixer_cmd),
	.loop_forever(loop_forever),
	.stolen      (stolen)
);

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

	localparam int NCH = vca_pkg::DEF_NUM_CHANNELS;
	localparam int STALL_LIMIT = 1000;
	localparam int SETTLE_CYCLES = NCH + 6;
	localparam logic [2:0] ACT_UNUSED = 3'd7;

	typedef struct packed {
		logic [2:0]  action;
		logic [7:0]  sound_id;
		logic        looping;
		logic [31:0] handle;
		logic [7:0]  playing_mask;
	} request_t;

	typedef struct packed {
		logic        status;
		logic [1:0]  sound_state;
		logic [2:0]  channel;
		logic [31:0] new_handle;
		logic [2:0]  mixer_cmd;
		logic        loop_forever;
		logic        stolen;
		logic [7:0]  freed_mask;
	} outcome_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  action = '0;
	logic [7:0]  sound_id = '0;
	logic        looping = 1'b0;
	logic [31:0] handle = '0;
	logic [7:0]  playing_mask = '0;
	logic        done;
	logic        status;
	logic [1:0]  sound_state;
	logic [2:0]  channel;
	logic [31:0] new_handle;
	logic [2:0]  mixer_cmd;
	logic        loop_forever;
	logic        stolen;
	logic [7:0]  freed_mask;

	logic        voice_valid [NCH];
	logic [31:0] voice_handle [NCH];
	logic [7:0]  voice_sound [NCH];
	logic        voice_loop [NCH];
	logic        voice_paused [NCH];
	logic [31:0] issued_handle;

	outcome_t pending_outcomes[$];
	int       mismatches = 0;
	int       stall_cycles = 0;
	bit       idling_on;

	voice_channel_allocator u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.sound_id(sound_id),
		.looping(looping),
		.handle(handle),
		.playing_mask(playing_mask),
		.done(done),
		.status(status),
		.sound_state(sound_state),
		.channel(channel),
		.new_handle(new_handle),
		.mixer_cmd(mixer_cmd),
		.loop_forever(loop_forever),
		.stolen(stolen),
		.freed_mask(freed_mask)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void clear_voice(int c);
		voice_valid[c] = 1'b0;
		voice_handle[c] = '0;
		voice_sound[c] = '0;
		voice_loop[c] = 1'b0;
		voice_paused[c] = 1'b0;
	endfunction

	function automatic int find_voice(logic [31:0] h);
		int hit;
		hit = -1;
		for (int c = NCH - 1; c >= 0; c--) begin
			if (voice_valid[c] && voice_handle[c] == h)
				hit = c;
		end
		return hit;
	endfunction

	function automatic int oldest_voice(logic [vca_pkg::CLASS_W-1:0] kind, logic [7:0] snd);
		int  best;
		logic ok;
		best = -1;
		for (int c = 0; c < NCH; c++) begin
			case (kind)
				vca_pkg::CLS_SAME:    ok = (voice_sound[c] == snd);
				vca_pkg::CLS_ONESHOT: ok = !voice_loop[c];
				default:              ok = 1'b1;
			endcase
			if (voice_valid[c] && ok && (best < 0 || voice_handle[c] < voice_handle[best]))
				best = c;
		end
		return best;
	endfunction

	function automatic outcome_t allocate_voice(request_t rq);
		outcome_t o;
		int k;
		o = '0;
		case (rq.action)
			vca_pkg::ACT_PLAY: begin
				k = -1;
				for (int c = NCH - 1; c >= 0; c--) begin
					if (!voice_valid[c])
						k = c;
				end
				if (k < 0) begin
					k = oldest_voice(vca_pkg::CLS_SAME, rq.sound_id);
					if (k < 0)
						k = oldest_voice(vca_pkg::CLS_ONESHOT, rq.sound_id);
					if (k < 0)
						k = oldest_voice(vca_pkg::CLS_ANY, rq.sound_id);
					o.stolen = 1'b1;
				end
				issued_handle = issued_handle + 32'd1;
				voice_valid[k] = 1'b1;
				voice_handle[k] = issued_handle;
				voice_sound[k] = rq.sound_id;
				voice_loop[k] = rq.looping;
				voice_paused[k] = 1'b0;
				o.channel = k[2:0];
				o.new_handle = issued_handle;
				o.mixer_cmd = vca_pkg::CMD_START;
				o.loop_forever = rq.looping;
			end
			vca_pkg::ACT_STOP, vca_pkg::ACT_PAUSE, vca_pkg::ACT_RESUME,
			vca_pkg::ACT_QUERY: begin
				k = find_voice(rq.handle);
				if (k < 0) begin
					o.status = vca_pkg::ST_NOT_FOUND;
				end else if (rq.action == vca_pkg::ACT_STOP) begin
					clear_voice(k);
					o.mixer_cmd = vca_pkg::CMD_HALT;
					o.channel = k[2:0];
				end else if (rq.action == vca_pkg::ACT_PAUSE) begin
					if (!voice_paused[k]) begin
						voice_paused[k] = 1'b1;
						o.mixer_cmd = vca_pkg::CMD_PAUSE;
						o.channel = k[2:0];
					end
				end else if (rq.action == vca_pkg::ACT_RESUME) begin
					if (voice_paused[k]) begin
						voice_paused[k] = 1'b0;
						o.mixer_cmd = vca_pkg::CMD_RESUME;
						o.channel = k[2:0];
					end
				end else begin
					o.sound_state = voice_paused[k] ? vca_pkg::SND_PAUSED : vca_pkg::SND_PLAYING;
				end
			end
			vca_pkg::ACT_STOP_ALL: begin
				for (int c = 0; c < NCH; c++)
					clear_voice(c);
				o.mixer_cmd = vca_pkg::CMD_HALT_ALL;
			end
			vca_pkg::ACT_UPDATE: begin
				for (int c = 0; c < NCH && c < 8; c++) begin
					if (voice_valid[c] && !rq.playing_mask[c]) begin
						clear_voice(c);
						o.freed_mask[c] = 1'b1;
					end
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		outcome_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_outcomes.size() == 0) begin
				$display("%0t: result beat with none expected, actual cmd %0h channel %0h",
					$time, mixer_cmd, channel);
				mismatches++;
			end else begin
				want = pending_outcomes.pop_front();
				check_field("status", 32'(want.status), 32'(status));
				check_field("sound_state", 32'(want.sound_state), 32'(sound_state));
				check_field("channel", 32'(want.channel), 32'(channel));
				check_field("new_handle", want.new_handle, new_handle);
				check_field("mixer_cmd", 32'(want.mixer_cmd), 32'(mixer_cmd));
				check_field("loop_forever", 32'(want.loop_forever), 32'(loop_forever));
				check_field("stolen", 32'(want.stolen), 32'(stolen));
				check_field("freed_mask", 32'(want.freed_mask), 32'(freed_mask));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && busy === 1'b0) || done === 1'b1) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic send_request(request_t rq);
		action <= rq.action;
		sound_id <= rq.sound_id;
		looping <= rq.looping;
		handle <= rq.handle;
		playing_mask <= rq.playing_mask;
		start <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		pending_outcomes.push_back(allocate_voice(rq));
	endtask

	task automatic send_fields(logic [2:0] a, logic [7:0] s, logic l, logic [31:0] h,
			logic [7:0] m);
		request_t rq;
		rq = '{action: a, sound_id: s, looping: l, handle: h, playing_mask: m};
		send_request(rq);
	endtask

	task automatic hold_off(int cycles);
		start <= 1'b0;
		action <= 3'($urandom);
		sound_id <= 8'($urandom);
		looping <= 1'($urandom);
		handle <= $urandom;
		playing_mask <= 8'($urandom);
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (pending_outcomes.size() != 0);
	endtask

	function automatic request_t random_request();
		request_t rq;
		int pick;
		logic [31:0] live[$];
		for (int c = 0; c < NCH; c++) begin
			if (voice_valid[c])
				live.push_back(voice_handle[c]);
		end
		pick = $urandom_range(0, 99);
		if (pick < 36)
			rq.action = vca_pkg::ACT_PLAY;
		else if (pick < 48)
			rq.action = vca_pkg::ACT_STOP;
		else if (pick < 60)
			rq.action = vca_pkg::ACT_PAUSE;
		else if (pick < 72)
			rq.action = vca_pkg::ACT_RESUME;
		else if (pick < 84)
			rq.action = vca_pkg::ACT_QUERY;
		else if (pick < 96)
			rq.action = vca_pkg::ACT_UPDATE;
		else if (pick < 98)
			rq.action = vca_pkg::ACT_STOP_ALL;
		else
			rq.action = ACT_UNUSED;
		rq.sound_id = $urandom_range(0, 1) ? 8'($urandom_range(0, 5)) : 8'($urandom);
		rq.looping = 1'($urandom);
		pick = $urandom_range(0, 9);
		if (pick < 6 && live.size() > 0)
			rq.handle = live[$urandom_range(0, live.size() - 1)];
		else if (pick < 8)
			rq.handle = issued_handle - 32'($urandom_range(0, 15));
		else
			rq.handle = $urandom;
		if ($urandom_range(0, 3) == 0)
			rq.playing_mask = 8'($urandom);
		else
			rq.playing_mask = ~(8'd1 << $urandom_range(0, 7));
		return rq;
	endfunction

	task automatic random_traffic(int count);
		repeat (count) begin
			if (idling_on && $urandom_range(0, 3) == 0)
				hold_off($urandom_range(1, 7));
			send_request(random_request());
		end
	endtask

	task automatic test_directed();
		send_fields(vca_pkg::ACT_QUERY, 8'h00, 1'b0, 32'h0000_0000, 8'h00);
		send_fields(vca_pkg::ACT_STOP, 8'hFF, 1'b1, 32'hFFFF_FFFF, 8'hFF);
		send_fields(vca_pkg::ACT_PAUSE, 8'h00, 1'b0, 32'd1, 8'h00);
		send_fields(vca_pkg::ACT_UPDATE, 8'h00, 1'b0, 32'd0, 8'h00);
		send_fields(vca_pkg::ACT_STOP_ALL, 8'h00, 1'b0, 32'd0, 8'h00);
		send_fields(ACT_UNUSED, 8'hFF, 1'b1, 32'hFFFF_FFFF, 8'hFF);
		send_fields(vca_pkg::ACT_PLAY, 8'h00, 1'b0, 32'd0, 8'h00);
		send_fields(vca_pkg::ACT_PLAY, 8'hFF, 1'b1, 32'd0, 8'h00);
		send_fields(vca_pkg::ACT_PAUSE, 8'h00, 1'b0, 32'd1, 8'h00);
		send_fields(vca_pkg::ACT_PAUSE, 8'h00, 1'b0, 32'd1, 8'h00);
		send_fields(vca_pkg::ACT_QUERY, 8'h00, 1'b0, 32'd1, 8'h00);
		send_fields(vca_pkg::ACT_RESUME, 8'h00, 1'b0, 32'd1, 8'h00);
		send_fields(vca_pkg::ACT_RESUME, 8'h00, 1'b0, 32'd1, 8'h00);
		send_fields(vca_pkg::ACT_STOP, 8'h00, 1'b0, 32'd1, 8'h00);
		send_fields(vca_pkg::ACT_STOP, 8'h00, 1'b0, 32'd1, 8'h00);
		send_fields(vca_pkg::ACT_STOP_ALL, 8'h00, 1'b0, 32'd0, 8'h00);
		for (int s = 1; s <= NCH; s++)
			send_fields(vca_pkg::ACT_PLAY, 8'(s), 1'b1, 32'd0, 8'h00);
		// With every channel busy, these steal by same sound, then from any voice,
		// then from the only one-shot voice.
		send_fields(vca_pkg::ACT_PLAY, 8'd3, 1'b1, 32'd0, 8'h00);
		send_fields(vca_pkg::ACT_PLAY, 8'd9, 1'b0, 32'd0, 8'h00);
		send_fields(vca_pkg::ACT_PLAY, 8'd10, 1'b1, 32'd0, 8'h00);
		send_fields(vca_pkg::ACT_UPDATE, 8'h00, 1'b0, 32'd0, 8'hAA);
	endtask

	task automatic test_random_with_gaps();
		idling_on = 1'b1;
		random_traffic(240);
		drain_results();
		random_traffic(240);
	endtask

	task automatic test_back_to_back();
		idling_on = 1'b0;
		random_traffic(100);
	endtask

	initial begin
		for (int c = 0; c < NCH; c++)
			clear_voice(c);
		issued_handle = '0;
		idling_on = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_with_gaps();
		test_back_to_back();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
